FILE: design/sha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg
// shared types and constants for the sha-256 message digest block
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int QueueDepth = 4;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
    } sha_item_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage
`default_nettype wire

FILE: design/sha256_message_digest_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_message_digest_top
// streaming sha-256 digest of a word-oriented message
// ----------------------------------------------------------------------------
// A four-entry input queue takes requests while the core works. Each word is
// fetched from the queue and its bytes are packed one per cycle, pausing while
// a full block is compressed and added into the hash. After the final word
// the padding bytes are packed one per cycle, pausing again while a block is
// compressed, one or two blocks are compressed in all, and the eight digest
// words leave one per cycle while the receiver is ready, index 0 first.
module sha256_message_digest_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // message_word, bytes_valid, zero fill
    input  wire logic        s_tlast,   // final_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0] m_tdata,        // digest_word, digest_index, zero fill
    output logic             m_tlast    // digest_last
);
    import sha_pkg::*;

    logic      q_valid, q_pop;
    sha_item_t q_item;
    logic [31:0] dw;
    logic [2:0]  di;

    sha_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_word(s_tdata[31:0]), .s_count(s_tdata[34:32]), .s_last(s_tlast),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    sha_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_word(dw), .m_index(di), .m_last(m_tlast)
    );

    assign m_tdata = {5'b0, di, dw};

endmodule
`default_nettype wire

FILE: design/sha_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_front
// accepts message words, clamps the byte count and queues them
// ----------------------------------------------------------------------------
module sha_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_word,
    input  wire logic [2:0]        s_count,
    input  wire logic              s_last,
    output logic                   q_valid,
    input  wire logic              q_pop,
    output sha_pkg::sha_item_t     q_item
);
    import sha_pkg::*;

    localparam int AW = $clog2(QueueDepth);

    sha_item_t       mem [QueueDepth];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            push, pop;
    sha_item_t       item;

    assign s_tready = (cnt_reg != (AW+1)'(QueueDepth));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem[rp_reg];

    always_comb
    begin
        item.word  = s_word;
        item.last  = s_last;
        item.count = (!s_last || s_count > 3'd4) ? 3'd4 : s_count;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(QueueDepth))
        else $error("queue overfull");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (AW+1)'(QueueDepth)) |-> !push)
        else $error("push into full queue");
    a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> item.count <= 3'd4)
        else $error("byte count too large");

endmodule
`default_nettype wire

FILE: design/sha_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_back
// packs bytes, pads, runs the 64 rounds and emits the digest
// ----------------------------------------------------------------------------
module sha_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  wire sha_pkg::sha_item_t q_item,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_word,
    output logic [2:0]             m_index,
    output logic                   m_last
);
    import sha_pkg::*;

    typedef enum logic [5:0] {
        ST_TAKE  = 6'b000001,
        ST_BYTE  = 6'b000010,
        ST_PAD   = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t        state_reg;
    sha_item_t     cur_reg;
    logic [1:0]    bi_reg;
    logic [31:0]   blk_reg [16];
    logic [5:0]    fill_reg;
    logic [60:0]   total_reg;
    logic [31:0]   h_reg [8];
    logic [31:0]   w_reg [16];
    logic [31:0]   a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, hh_reg;
    logic [5:0]    rnd_reg;
    logic          padding_reg;
    logic [3:0]    pad_i_reg;
    logic [2:0]    oi_reg;
    logic [63:0]   bits_reg;

    logic [7:0]    pbyte;
    logic          do_push;
    logic [31:0]   wt, s0, s1, w_new, t1, t2, bs1, bs0, ch, mj;

    assign q_pop = (state_reg == ST_TAKE) && q_valid;

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_word   = h_reg[oi_reg];
    assign m_index  = oi_reg;
    assign m_last   = (oi_reg == 3'd7);

    always_comb
    begin
        wt    = w_reg[0];
        s0    = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
                ^ (w_reg[1] >> 3);
        s1    = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
                ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        bs1   = {e_reg[5:0], e_reg[31:6]} ^ {e_reg[10:0], e_reg[31:11]}
                ^ {e_reg[24:0], e_reg[31:25]};
        ch    = (e_reg & f_reg) ^ (~e_reg & g_reg);
        t1    = hh_reg + bs1 + ch + ROUND_K[rnd_reg] + wt;
        bs0   = {a_reg[1:0], a_reg[31:2]} ^ {a_reg[12:0], a_reg[31:13]}
                ^ {a_reg[21:0], a_reg[31:22]};
        mj    = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
        t2    = bs0 + mj;
    end

    always_comb
    begin
        pbyte   = 8'h00;
        do_push = 1'b0;
        if (state_reg == ST_BYTE)
        begin
            do_push = (bi_reg < cur_reg.count[1:0]) || (cur_reg.count == 3'd4);
            pbyte   = cur_reg.word[31 - 8*bi_reg -: 8];
        end
        else if (state_reg == ST_PAD)
        begin
            do_push = 1'b1;
            if (!padding_reg)
                pbyte = PAD_BYTE;
            else if (pad_i_reg[3])
                pbyte = bits_reg[63 - 8*pad_i_reg[2:0] -: 8];
            else
                pbyte = 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TAKE && q_valid)
        begin
            cur_reg <= q_item;
        end
        if (do_push)
        begin
            if (fill_reg[1:0] == 2'd0)
                blk_reg[fill_reg[5:2]] <= {pbyte, 24'h0};
            else
                blk_reg[fill_reg[5:2]][31 - 8*fill_reg[1:0] -: 8] <= pbyte;
        end
        if (do_push && fill_reg == 6'd63)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= blk_reg[i];
            w_reg[15] <= {blk_reg[15][31:8], pbyte};
            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2]; d_reg <= h_reg[3];
            e_reg <= h_reg[4]; f_reg <= h_reg[5]; g_reg <= h_reg[6]; hh_reg <= h_reg[7];
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            hh_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_TAKE;
            bi_reg      <= '0;
            fill_reg    <= '0;
            total_reg   <= '0;
            rnd_reg     <= '0;
            padding_reg <= 1'b0;
            pad_i_reg   <= '0;
            oi_reg      <= '0;
            bits_reg    <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= IV[i];
        end
        else
        begin
            if (do_push)
                fill_reg <= fill_reg + 6'd1;
            unique case (state_reg)
                ST_TAKE:
                begin
                    if (q_valid)
                    begin
                        bi_reg    <= '0;
                        state_reg <= ST_BYTE;
                    end
                end
                ST_BYTE:
                begin
                    bi_reg <= bi_reg + 2'd1;
                    if (do_push && fill_reg == 6'd63)
                    begin
                        rnd_reg   <= '0;
                        state_reg <= ST_ROUND;
                    end
                    else if (bi_reg == 2'd3)
                    begin
                        total_reg <= total_reg + 61'(cur_reg.count);
                        if (cur_reg.last)
                        begin
                            bits_reg    <= {total_reg + 61'(cur_reg.count), 3'b000};
                            padding_reg <= 1'b0;
                            state_reg   <= ST_PAD;
                        end
                        else
                            state_reg <= ST_TAKE;
                    end
                end
                ST_PAD:
                begin
                    if (padding_reg && pad_i_reg[3])
                        pad_i_reg <= pad_i_reg + 4'd1;
                    else if (fill_reg == 6'd55)
                        pad_i_reg <= 4'd8;
                    else if (!padding_reg)
                        pad_i_reg <= 4'd1;
                    padding_reg <= 1'b1;
                    if (fill_reg == 6'd63)
                    begin
                        rnd_reg   <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                        state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg; h_reg[5] <= h_reg[5] + f_reg;
                    h_reg[6] <= h_reg[6] + g_reg; h_reg[7] <= h_reg[7] + hh_reg;
                    if (padding_reg && pad_i_reg == 4'd0)
                    begin
                        oi_reg    <= '0;
                        state_reg <= ST_OUT;
                    end
                    else if (padding_reg)
                        state_reg <= ST_PAD;
                    else if (bi_reg == 2'd0)
                    begin
                        total_reg <= total_reg + 61'(cur_reg.count);
                        if (cur_reg.last)
                        begin
                            bits_reg    <= {total_reg + 61'(cur_reg.count), 3'b000};
                            padding_reg <= 1'b0;
                            state_reg   <= ST_PAD;
                        end
                        else
                            state_reg <= ST_TAKE;
                    end
                    else
                        state_reg <= ST_BYTE;
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        oi_reg <= oi_reg + 3'd1;
                        if (oi_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= IV[i];
                            total_reg   <= '0;
                            fill_reg    <= '0;
                            padding_reg <= 1'b0;
                            pad_i_reg   <= '0;
                            state_reg   <= ST_TAKE;
                        end
                    end
                end
                default: state_reg <= ST_TAKE;
            endcase
        end
    end

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> fill_reg == 6'd0)
        else $error("digest out with partial block");
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> state_reg == ST_ADD)
        else $error("round counter slip");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(oi_reg))
        else $error("digest word dropped");

endmodule
`default_nettype wire

FILE: dv/sha256_message_digest_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_digest_top_tb
// streams random and directed messages into the digest block and checks every
// digest word against an in-bench sha-256 predictor, with random stalls on
// both sides and one long output hold-off that backs up the input
// ----------------------------------------------------------------------------
module sha256_message_digest_top_tb;

    import sha_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
    } msg_req_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    msg_req_t pending_reqs[$];
    digest_t  digest_fifo[$];

    logic [31:0] hash_state[8];
    logic [31:0] buf_words[16];
    logic [60:0] byte_count;
    logic [5:0]  fill_count;

    int errors;
    int digests_seen;
    int reqs_sent;
    int messages_sent;
    bit no_idle;
    bit hold_go;
    logic hold_active;

    sha256_message_digest_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] rotr(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void compress();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = buf_words[i];
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void pack_byte(logic [7:0] x);
        int wi;
        int lane;
        wi = fill_count[5:2];
        lane = fill_count[1:0];
        if (lane == 0)
            buf_words[wi] = '0;
        buf_words[wi] |= 32'(x) << (24 - 8 * lane);
        fill_count = fill_count + 6'd1;
        if (fill_count == 0)
            compress();
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            hash_state[i] = IV[i];
        byte_count = '0;
        fill_count = '0;
    endfunction

    function automatic void predict_digest(msg_req_t r);
        int n;
        logic [63:0] bits;
        digest_t d;
        n = (!r.last || r.count > 4) ? 4 : r.count;
        for (int i = 0; i < n; i++)
            pack_byte(r.word[31 - 8 * i -: 8]);
        byte_count = byte_count + 61'(n);
        if (!r.last)
            return;
        bits = {byte_count, 3'b000};
        pack_byte(PAD_BYTE);
        while (fill_count != 6'd56)
            pack_byte(8'h00);
        for (int i = 0; i < 8; i++)
            pack_byte(bits[63 - 8 * i -: 8]);
        for (int i = 0; i < 8; i++)
        begin
            d.word = hash_state[i];
            d.index = 3'(i);
            d.last = (i == 7);
            digest_fifo = {digest_fifo, d};
        end
        restart_hash();
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
        $display("mismatch %s: got %h expected %h (digest word %0d)",
                 what, got, exp, digests_seen);
        errors++;
    endtask

    function automatic void add_message(int nwords, int tail);
        msg_req_t r;
        for (int i = 0; i < nwords; i++)
        begin
            r.word = $urandom;
            r.count = 3'($urandom_range(0, 7));
            r.last = 1'b0;
            pending_reqs = {pending_reqs, r};
        end
        r.word = $urandom;
        r.count = 3'(tail);
        r.last = 1'b1;
        pending_reqs = {pending_reqs, r};
        messages_sent++;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_digest(pending_reqs.pop_front());
                reqs_sent++;
            end
            if ((!s_tvalid || s_tready) && pending_reqs.size() > 0
                && !(s_tvalid && s_tready && pending_reqs.size() == 0))
            begin
                if (no_idle || $urandom_range(0, 99) >= 35)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'b0, pending_reqs[0].count, pending_reqs[0].word};
                    s_tlast <= pending_reqs[0].last;
                end
                else
                    s_tvalid <= 1'b0;
            end
            else if (s_tvalid && s_tready)
                s_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off
    initial
    begin
        hold_active = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (400) @(posedge clk);
        hold_active <= 1'b0;
    end

    // monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (digest_fifo.size() == 0)
                    report_mismatch("unexpected", m_tdata[31:0], 32'd0);
                else
                begin
                    digest_t x;
                    x = digest_fifo.pop_front();
                    if (m_tdata[31:0] !== x.word)
                        report_mismatch("word", m_tdata[31:0], x.word);
                    if (m_tdata[34:32] !== x.index)
                        report_mismatch("index", 32'(m_tdata[34:32]), 32'(x.index));
                    if (m_tdata[39:35] !== '0)
                        report_mismatch("fill", 32'(m_tdata[39:35]), 32'd0);
                    if (m_tlast !== x.last)
                        report_mismatch("last", 32'(m_tlast), 32'(x.last));
                end
                digests_seen++;
            end
            if (hold_active)
                m_tready <= 1'b0;
            else
                m_tready <= no_idle || $urandom_range(0, 99) >= 35;
        end
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d digest words outstanding", digest_fifo.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        errors = 0;
        digests_seen = 0;
        reqs_sent = 0;
        messages_sent = 0;
        no_idle = 0;
        hold_go = 0;
        restart_hash();
        for (int i = 0; i < 16; i++)
            buf_words[i] = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty message, short tails, oversized count, one-block boundaries
        add_message(0, 0);
        add_message(0, 3);
        add_message(0, 7);
        pending_reqs = {pending_reqs, msg_req_t'{32'hffffffff, 3'd4, 1'b0}};
        pending_reqs = {pending_reqs, msg_req_t'{32'h00000000, 3'd1, 1'b1}};
        messages_sent++;
        add_message(13, 4);
        add_message(14, 0);
        for (int i = 0; i < 15; i++)
            @(posedge clk);
        while (pending_reqs.size() > 0)
            @(posedge clk);

        // long output hold-off with the sender still pushing
        hold_go = 1'b1;
        add_message(20, 2);
        while (pending_reqs.size() > 0)
            @(posedge clk);

        // random messages, one stretch without idling
        while (reqs_sent < 102)
        begin
            no_idle = (reqs_sent > 60 && reqs_sent < 90);
            add_message($urandom_range(0, 18), $urandom_range(0, 7));
            while (pending_reqs.size() > 0)
                @(posedge clk);
        end
        no_idle = 0;
        while (digest_fifo.size() > 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < 300)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        $display("%0d requests in %0d messages, %0d digest words checked",
                 reqs_sent, messages_sent, digests_seen);
        if (errors == 0 && digest_fifo.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
design/sha_pkg.sv
design/sha_front.sv
design/sha_back.sv
design/sha256_message_digest_top.sv
dv/sha256_message_digest_top_tb.sv
